FILE: sv/bhs_pkg.sv
// bhs_pkg: shared types, codes and reset values for the bootstrap handshake sequencer
// no dependencies; used by the interfaces, the csr bank, the core and the top level
package bhs_pkg;

   // field widths
   localparam int OP_BITS    = 2;
   localparam int STAMP_BITS = 32;
   localparam int CFG_BITS   = 32;
   localparam int PHASE_BITS = 3;
   localparam int CSR_IDX_BITS = 2;

   // default timestamp width used for the internal time arithmetic
   localparam int TIME_BITS_DEFAULT = 32;

   // configuration register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_HELLO_RETRY = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_READY_RETRY = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_OVERALL_TMO = 2'd2;

   // configuration reset values
   localparam logic [CFG_BITS-1:0] HELLO_RETRY_RESET = 32'd1000;
   localparam logic [CFG_BITS-1:0] READY_RETRY_RESET = 32'd1000;
   localparam logic [CFG_BITS-1:0] OVERALL_TMO_RESET = 32'd10000;

   // request operations
   typedef enum logic [OP_BITS-1:0] {
      OP_RESTART       = 2'd0,
      OP_TICK          = 2'd1,
      OP_SERVER_HELLO  = 2'd2,
      OP_RUNTIME_START = 2'd3
   } op_type;

   // bring-up phases, one-hot
   typedef enum logic [5:0] {
      PH_INIT       = 6'b000001,
      PH_WAIT_HELLO = 6'b000010,
      PH_WAIT_START = 6'b000100,
      PH_READY      = 6'b001000,
      PH_RUNNING    = 6'b010000,
      PH_FAILED     = 6'b100000
   } phase_type;

   // phase codes as seen on the response
   localparam logic [PHASE_BITS-1:0] PHASE_CODE_INIT       = 3'd0;
   localparam logic [PHASE_BITS-1:0] PHASE_CODE_WAIT_HELLO = 3'd1;
   localparam logic [PHASE_BITS-1:0] PHASE_CODE_WAIT_START = 3'd2;
   localparam logic [PHASE_BITS-1:0] PHASE_CODE_READY      = 3'd3;
   localparam logic [PHASE_BITS-1:0] PHASE_CODE_RUNNING    = 3'd4;
   localparam logic [PHASE_BITS-1:0] PHASE_CODE_FAILED     = 3'd5;

   // configuration set handed from the csr bank to the core
   typedef struct packed {
      logic [CFG_BITS-1:0] hello_retry_interval;
      logic [CFG_BITS-1:0] ready_retry_interval;
      logic [CFG_BITS-1:0] overall_timeout;
   } cfg_type;

   // one response item
   typedef struct packed {
      logic                  send_client_hello;
      logic                  send_runtime_ready;
      logic [PHASE_BITS-1:0] phase_now;
      logic                  is_running;
      logic                  event_ignored;
   } rsp_type;

   // one-hot phase to response code
   function automatic logic [PHASE_BITS-1:0] phase_code(input phase_type ph);
      logic [PHASE_BITS-1:0] code;
      unique case (ph)
         PH_INIT:       code = PHASE_CODE_INIT;
         PH_WAIT_HELLO: code = PHASE_CODE_WAIT_HELLO;
         PH_WAIT_START: code = PHASE_CODE_WAIT_START;
         PH_READY:      code = PHASE_CODE_READY;
         PH_RUNNING:    code = PHASE_CODE_RUNNING;
         PH_FAILED:     code = PHASE_CODE_FAILED;
         default:       code = PHASE_CODE_INIT;
      endcase
      return code;
   endfunction

endpackage

FILE: sv/bhs_req_if.sv
// bhs_req_if: request channel of the bootstrap handshake sequencer
// depends on bhs_pkg for the field widths
interface bhs_req_if;
   import bhs_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [OP_BITS-1:0]    operation;
   logic [STAMP_BITS-1:0] time_now;

   modport source (output valid, output operation, output time_now, input ready);
   modport sink   (input valid, input operation, input time_now, output ready);
endinterface

FILE: sv/bhs_rsp_if.sv
// bhs_rsp_if: response channel of the bootstrap handshake sequencer
// depends on bhs_pkg for the field widths
interface bhs_rsp_if;
   import bhs_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  send_client_hello;
   logic                  send_runtime_ready;
   logic [PHASE_BITS-1:0] phase_now;
   logic                  is_running;
   logic                  event_ignored;

   modport source (output valid, output send_client_hello, output send_runtime_ready,
                   output phase_now, output is_running, output event_ignored,
                   input ready);
   modport sink   (input valid, input send_client_hello, input send_runtime_ready,
                   input phase_now, input is_running, input event_ignored,
                   output ready);
endinterface

FILE: sv/bhs_csr.sv
// bhs_csr: configuration register bank (retry intervals and overall timeout)
// depends on bhs_pkg for register indexes, reset values and cfg_type
module bhs_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [bhs_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [bhs_pkg::CFG_BITS-1:0]      csr_wdata,
   output bhs_pkg::cfg_type                  cfg
);
   import bhs_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register write decode; indexes past the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_HELLO_RETRY: cfg_in.hello_retry_interval = csr_wdata;
            CSR_READY_RETRY: cfg_in.ready_retry_interval = csr_wdata;
            CSR_OVERALL_TMO: cfg_in.overall_timeout      = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hello_retry_interval <= HELLO_RETRY_RESET;
         cfg_ff.ready_retry_interval <= READY_RETRY_RESET;
         cfg_ff.overall_timeout      <= OVERALL_TMO_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

FILE: sv/bhs_core.sv
// bhs_core: phase state and timestamps, plus the single-pass next-state and response logic
// depends on bhs_pkg for op_type, phase_type, cfg_type and rsp_type
module bhs_core #(
   parameter int TIME_BITS = bhs_pkg::TIME_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  logic [bhs_pkg::OP_BITS-1:0]       operation,
   input  logic [bhs_pkg::STAMP_BITS-1:0]    time_now,
   input  bhs_pkg::cfg_type                  cfg,
   output bhs_pkg::rsp_type                  rsp
);
   import bhs_pkg::*;

   localparam int CMP_BITS = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;

   phase_type            phase_ff, phase_in;
   logic [TIME_BITS-1:0] start_time_ff, start_time_in;
   logic [TIME_BITS-1:0] last_hello_ff, last_hello_in;
   logic [TIME_BITS-1:0] last_ready_ff, last_ready_in;

   logic [TIME_BITS-1:0] now_t;
   logic [TIME_BITS-1:0] since_start;
   logic [TIME_BITS-1:0] since_hello;
   logic [TIME_BITS-1:0] since_ready;
   logic                 timeout;
   logic                 hello_due;
   logic                 ready_due;
   op_type               op;
   logic                 hello, ready, ignored;

   // elapsed times wrap modulo 2^TIME_BITS
   assign now_t       = TIME_BITS'(time_now);
   assign since_start = now_t - start_time_ff;
   assign since_hello = now_t - last_hello_ff;
   assign since_ready = now_t - last_ready_ff;

   assign timeout   = CMP_BITS'(since_start) >= CMP_BITS'(cfg.overall_timeout);
   assign hello_due = CMP_BITS'(since_hello) >= CMP_BITS'(cfg.hello_retry_interval);
   assign ready_due = CMP_BITS'(since_ready) >= CMP_BITS'(cfg.ready_retry_interval);

   assign op = op_type'(operation);

   // next phase and send decisions for one request
   always_comb begin
      phase_in      = phase_ff;
      start_time_in = start_time_ff;
      last_hello_in = last_hello_ff;
      last_ready_in = last_ready_ff;
      hello         = 1'b0;
      ready         = 1'b0;
      ignored       = 1'b0;
      unique case (op)
         OP_RESTART: begin
            phase_in      = PH_INIT;
            start_time_in = now_t;
            last_hello_in = '0;
            last_ready_in = '0;
         end
         OP_TICK: begin
            unique case (phase_ff)
               PH_INIT: begin
                  if (timeout) begin
                     phase_in = PH_FAILED;
                  end else begin
                     phase_in      = PH_WAIT_HELLO;
                     last_hello_in = now_t;
                     hello         = 1'b1;
                  end
               end
               PH_WAIT_HELLO: begin
                  if (timeout) begin
                     phase_in = PH_FAILED;
                  end else if (hello_due) begin
                     last_hello_in = now_t;
                     hello         = 1'b1;
                  end
               end
               PH_WAIT_START: begin
                  if (timeout) begin
                     phase_in = PH_FAILED;
                  end else if (ready_due) begin
                     last_ready_in = now_t;
                     ready         = 1'b1;
                  end
               end
               PH_READY: begin
                  phase_in = PH_RUNNING;
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
         OP_SERVER_HELLO: begin
            if (phase_ff == PH_WAIT_HELLO) begin
               phase_in      = PH_WAIT_START;
               last_ready_in = now_t;
               ready         = 1'b1;
            end else begin
               ignored = 1'b1;
            end
         end
         OP_RUNTIME_START: begin
            if (phase_ff == PH_WAIT_START) begin
               phase_in = PH_READY;
            end else begin
               ignored = 1'b1;
            end
         end
         default: begin
            ignored = 1'b0;
         end
      endcase
   end

   // response for this request
   always_comb begin
      rsp.send_client_hello  = hello;
      rsp.send_runtime_ready = ready;
      rsp.phase_now          = phase_code(phase_in);
      rsp.is_running         = (phase_in == PH_RUNNING);
      rsp.event_ignored      = ignored;
   end

   // state update when the request moves into the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_INIT;
         start_time_ff <= '0;
         last_hello_ff <= '0;
         last_ready_ff <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         start_time_ff <= start_time_in;
         last_hello_ff <= last_hello_in;
         last_ready_ff <= last_ready_in;
      end
   end
endmodule

FILE: sv/bootstrap_handshake_sequencer_top.sv
// bootstrap handshake sequencer, top level: request register, core, response register
// a request is held in the request register until it moves into the response register
// throughput: one request per cycle while the response channel does not stall
// reset (synchronous): phase init, timestamps zero, intervals 1000/1000, timeout 10000
// depends on bhs_pkg, bhs_req_if, bhs_rsp_if, bhs_csr and bhs_core
module bootstrap_handshake_sequencer_top #(
   parameter int TIME_BITS = bhs_pkg::TIME_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   bhs_req_if.sink                           req_chan,
   bhs_rsp_if.source                         rsp_chan,
   input  logic                              csr_we,
   input  logic [bhs_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [bhs_pkg::CFG_BITS-1:0]      csr_wdata
);
   import bhs_pkg::*;

   cfg_type               cfg;
   rsp_type               core_rsp;

   logic                  in_valid_ff, in_valid_in;
   logic [OP_BITS-1:0]    in_op_ff;
   logic [STAMP_BITS-1:0] in_time_ff;
   logic                  out_valid_ff, out_valid_in;
   rsp_type               out_rsp_ff;

   logic                  advance;
   logic                  req_take;

   // pipeline moves when the response register is empty or being drained
   assign advance  = !out_valid_ff || rsp_chan.ready;
   assign req_take = req_chan.valid && req_chan.ready;
   assign req_chan.ready = advance || !in_valid_ff;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff   <= req_chan.operation;
         in_time_ff <= req_chan.time_now;
      end
   end

   bhs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bhs_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance && in_valid_ff),
      .operation (in_op_ff),
      .time_now  (in_time_ff),
      .cfg       (cfg),
      .rsp       (core_rsp)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         out_rsp_ff <= core_rsp;
      end
   end

   assign rsp_chan.valid              = out_valid_ff;
   assign rsp_chan.send_client_hello  = out_rsp_ff.send_client_hello;
   assign rsp_chan.send_runtime_ready = out_rsp_ff.send_runtime_ready;
   assign rsp_chan.phase_now          = out_rsp_ff.phase_now;
   assign rsp_chan.is_running         = out_rsp_ff.is_running;
   assign rsp_chan.event_ignored      = out_rsp_ff.event_ignored;
endmodule

FILE: tb/testbench.sv
// testbench for bootstrap_handshake_sequencer_top: directed bring-up cases, then random
// sessions over several register settings, checked against an in-bench phase predictor
// depends on bhs_pkg, bhs_req_if, bhs_rsp_if and the sequencer rtl
`timescale 1ns / 100ps

module testbench;
   import bhs_pkg::*;

   localparam int DRAIN_LIMIT = 20000;
   localparam logic [31:0] STAMP_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      op_type                op;
      logic [STAMP_BITS-1:0] stamp;
   } bring_up_req_type;

   logic                    clock;
   logic                    reset;
   logic                    csr_we;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [CFG_BITS-1:0]     csr_wdata;

   bhs_req_if req_chan ();
   bhs_rsp_if rsp_chan ();

   bootstrap_handshake_sequencer_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // request and response bookkeeping
   bring_up_req_type pending_reqs[$];
   rsp_type          expected_rsps[$];
   int               reqs_queued = 0;
   int               reqs_taken = 0;
   int               mismatches = 0;
   bit               req_took = 1'b0;
   bit               rsp_took = 1'b0;

   // predictor copy of the registers and the bring-up state
   logic [CFG_BITS-1:0]   hello_gap;
   logic [CFG_BITS-1:0]   ready_gap;
   logic [CFG_BITS-1:0]   give_up_after;
   logic [PHASE_BITS-1:0] ph;
   logic [STAMP_BITS-1:0] started_at;
   logic [STAMP_BITS-1:0] hello_sent_at;
   logic [STAMP_BITS-1:0] ready_sent_at;

   // random timestamp walk
   logic [STAMP_BITS-1:0] wall = '0;
   int unsigned           step_span = 100;

   // clock, 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // advance the predicted bring-up state by one request
   function automatic rsp_type bring_up_step(input op_type op, input logic [STAMP_BITS-1:0] now);
      rsp_type res;
      logic    timed_out;
      res = '0;
      timed_out = (now - started_at) >= give_up_after;
      case (op)
         OP_RESTART: begin
            ph = PHASE_CODE_INIT;
            started_at = now;
            hello_sent_at = '0;
            ready_sent_at = '0;
         end
         OP_TICK: begin
            case (ph)
               PHASE_CODE_INIT: begin
                  if (timed_out) ph = PHASE_CODE_FAILED;
                  else begin
                     ph = PHASE_CODE_WAIT_HELLO;
                     hello_sent_at = now;
                     res.send_client_hello = 1'b1;
                  end
               end
               PHASE_CODE_WAIT_HELLO: begin
                  if (timed_out) ph = PHASE_CODE_FAILED;
                  else if ((now - hello_sent_at) >= hello_gap) begin
                     hello_sent_at = now;
                     res.send_client_hello = 1'b1;
                  end
               end
               PHASE_CODE_WAIT_START: begin
                  if (timed_out) ph = PHASE_CODE_FAILED;
                  else if ((now - ready_sent_at) >= ready_gap) begin
                     ready_sent_at = now;
                     res.send_runtime_ready = 1'b1;
                  end
               end
               PHASE_CODE_READY: ph = PHASE_CODE_RUNNING;
               default: ;
            endcase
         end
         OP_SERVER_HELLO: begin
            if (ph == PHASE_CODE_WAIT_HELLO) begin
               ph = PHASE_CODE_WAIT_START;
               ready_sent_at = now;
               res.send_runtime_ready = 1'b1;
            end else res.event_ignored = 1'b1;
         end
         default: begin
            if (ph == PHASE_CODE_WAIT_START) ph = PHASE_CODE_READY;
            else res.event_ignored = 1'b1;
         end
      endcase
      res.phase_now = ph;
      res.is_running = (ph == PHASE_CODE_RUNNING);
      return res;
   endfunction

   function automatic void check_field(input string field, input logic [PHASE_BITS-1:0] want,
                                       input logic [PHASE_BITS-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endfunction

   // wait count for one request or response, zero throughout a calm stretch
   function automatic int draw_wait(input bit calm);
      return calm ? 0 : $urandom_range(0, 10);
   endfunction

   // accepted requests feed the predictor, accepted responses are checked in order
   always @(posedge clock) begin
      rsp_type want;
      req_took = 1'b0;
      rsp_took = 1'b0;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            req_took = 1'b1;
            reqs_taken++;
            expected_rsps.push_back(bring_up_step(op_type'(req_chan.operation),
                                                  req_chan.time_now));
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            rsp_took = 1'b1;
            if (expected_rsps.size() == 0) begin
               $error("response with no request outstanding");
               mismatches++;
            end else begin
               want = expected_rsps.pop_front();
               check_field("send_client_hello", PHASE_BITS'(want.send_client_hello),
                           PHASE_BITS'(rsp_chan.send_client_hello));
               check_field("send_runtime_ready", PHASE_BITS'(want.send_runtime_ready),
                           PHASE_BITS'(rsp_chan.send_runtime_ready));
               check_field("phase_now", want.phase_now, rsp_chan.phase_now);
               check_field("is_running", PHASE_BITS'(want.is_running),
                           PHASE_BITS'(rsp_chan.is_running));
               check_field("event_ignored", PHASE_BITS'(want.event_ignored),
                           PHASE_BITS'(rsp_chan.event_ignored));
            end
         end
      end
   end

   // request driver, one pending request at a time with a random gap after each
   always @(negedge clock) begin
      int               gap_left;
      bit               send_calm;
      bring_up_req_type nxt;
      if (reset) begin
         req_chan.valid <= 1'b0;
         gap_left = 0;
      end else if (!req_chan.valid || req_took) begin
         if (gap_left > 0) begin
            gap_left--;
            req_chan.valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            nxt = pending_reqs.pop_front();
            req_chan.valid <= 1'b1;
            req_chan.operation <= nxt.op;
            req_chan.time_now <= nxt.stamp;
            if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
            gap_left = draw_wait(send_calm);
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // response stalls, drawn after each accepted response
   always @(negedge clock) begin
      int stall_left;
      bit take_calm;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_took) begin
            if ($urandom_range(0, 39) == 0) take_calm = !take_calm;
            stall_left = draw_wait(take_calm);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   task automatic push_req(input op_type op, input logic [STAMP_BITS-1:0] stamp);
      bring_up_req_type item;
      item.op = op;
      item.stamp = stamp;
      pending_reqs.push_back(item);
      reqs_queued++;
   endtask

   // mostly small forward steps, sometimes a repeat or a jump anywhere
   function automatic logic [STAMP_BITS-1:0] next_stamp();
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick == 1) wall = $urandom;
      else if (pick != 0) wall = wall + $urandom_range(0, step_span);
      return wall;
   endfunction

   // one slot of a session: sometimes dropped, sometimes preceded by a stray request
   task automatic push_noisy(input op_type op);
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick < 3) push_req(op_type'($urandom_range(0, 3)), next_stamp());
      if (pick != 0) push_req(op, next_stamp());
   endtask

   // restart, hello exchange, runtime start, then ticks into running
   task automatic queue_session();
      int k;
      push_noisy(OP_RESTART);
      k = $urandom_range(1, 4);
      repeat (k) push_noisy(OP_TICK);
      push_noisy(OP_SERVER_HELLO);
      k = $urandom_range(0, 4);
      repeat (k) push_noisy(OP_TICK);
      push_noisy(OP_RUNTIME_START);
      k = $urandom_range(0, 3);
      repeat (k) push_noisy(OP_TICK);
   endtask

   // sender holds back until every request has its response
   task automatic wait_idle();
      int spins;
      spins = 0;
      while ((reqs_taken != reqs_queued || expected_rsps.size() != 0) && spins < DRAIN_LIMIT) begin
         @(negedge clock);
         spins++;
      end
      if (spins >= DRAIN_LIMIT) begin
         $error("responses still outstanding: %0d", expected_rsps.size());
         mismatches++;
         expected_rsps.delete();
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_HELLO_RETRY: hello_gap = val;
         CSR_READY_RETRY: ready_gap = val;
         CSR_OVERALL_TMO: give_up_after = val;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // new register setting on an idle block, then random sessions
   task automatic run_phase(input logic [31:0] hello_val, input logic [31:0] ready_val,
                            input logic [31:0] tmo_val, input int count);
      longint unsigned span;
      int              target;
      wait_idle();
      write_csr(CSR_HELLO_RETRY, hello_val);
      write_csr(CSR_READY_RETRY, ready_val);
      write_csr(CSR_OVERALL_TMO, tmo_val);
      span = tmo_val / 4;
      if (hello_val < span) span = hello_val;
      if (ready_val < span) span = ready_val;
      if (span < 2) span = 2;
      if (span > 50000) span = 50000;
      step_span = 32'(span);
      target = reqs_queued + count;
      while (reqs_queued < target) queue_session();
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.operation = '0;
      req_chan.time_now = '0;
      rsp_chan.ready = 1'b0;
      hello_gap = HELLO_RETRY_RESET;
      ready_gap = READY_RETRY_RESET;
      give_up_after = OVERALL_TMO_RESET;
      ph = PHASE_CODE_INIT;
      started_at = '0;
      hello_sent_at = '0;
      ready_sent_at = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // full bring-up at reset settings, retries on the exact interval boundary
      push_req(OP_TICK, 32'd5);
      push_req(OP_RUNTIME_START, 32'd6);
      push_req(OP_TICK, 32'd500);
      push_req(OP_TICK, 32'd1005);
      push_req(OP_SERVER_HELLO, 32'd1100);
      push_req(OP_SERVER_HELLO, 32'd1101);
      push_req(OP_TICK, 32'd2099);
      push_req(OP_TICK, 32'd2100);
      push_req(OP_RUNTIME_START, 32'd2200);
      push_req(OP_RUNTIME_START, 32'd2201);
      push_req(OP_SERVER_HELLO, 32'd2202);
      push_req(OP_TICK, 32'd2300);
      push_req(OP_TICK, 32'd2400);
      // timestamps wrapping, timeout while waiting for the server hello
      push_req(OP_RESTART, 32'hFFFF_FF00);
      push_req(OP_TICK, 32'h0000_0010);
      push_req(OP_TICK, 32'd9743);
      push_req(OP_TICK, 32'd9744);
      push_req(OP_TICK, 32'd9800);
      push_req(OP_SERVER_HELLO, 32'd9801);
      push_req(OP_RUNTIME_START, 32'd9802);
      // timeout on the first tick after restart
      push_req(OP_RESTART, STAMP_MAX);
      push_req(OP_TICK, 32'd9999);
      // timeout while waiting for runtime start
      push_req(OP_RESTART, 32'd0);
      push_req(OP_TICK, 32'd200);
      push_req(OP_SERVER_HELLO, 32'd300);
      push_req(OP_TICK, 32'd10000);

      // each phase boundary also holds the sender until the block has drained
      run_phase(32'd1, 32'd1, 32'd1, 120);
      run_phase(STAMP_MAX, STAMP_MAX, STAMP_MAX, 120);
      run_phase(32'd0, 32'd0, 32'd0, 60);
      run_phase(32'd0, 32'd0, STAMP_MAX, 100);
      run_phase(32'd50, 32'd80, 32'd600, 150);
      repeat (6) begin
         run_phase($urandom_range(1, 300), $urandom_range(1, 300), $urandom_range(200, 4000), 130);
      end
      wait_idle();

      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // hang guard
   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: sim.f
sv/bhs_pkg.sv
sv/bhs_req_if.sv
sv/bhs_rsp_if.sv
sv/bhs_csr.sv
sv/bhs_core.sv
sv/bootstrap_handshake_sequencer_top.sv
tb/testbench.sv
